// ===== rtl/irct_pkg.sv =====
// Shared types and constants for the IRC line tokenizer.
`default_nettype none
package irct_pkg;

  localparam int DEF_MAX_PARAMS = 16;

  localparam int            LIMIT_W            = 5;
  localparam int            LEN_LIMIT_W        = 11;
  localparam int            PENDING_W          = 12;
  localparam logic [4:0]    RESET_PARAM_LIMIT  = 5'd16;
  localparam logic [10:0]   RESET_MAX_LINE     = 11'd1024;

  localparam logic REG_PARAM_LIMIT    = 1'b0;
  localparam logic REG_MAX_LINE_BYTES = 1'b1;

  typedef enum logic [3:0] {
    PH_START      = 4'd0,
    PH_TAGS       = 4'd1,
    PH_PFXOPT     = 4'd2,
    PH_PREFIX     = 4'd3,
    PH_CMDSTART   = 4'd4,
    PH_CMDNUM     = 4'd5,
    PH_CMDALPHA   = 4'd6,
    PH_AFTER      = 4'd7,
    PH_PARAMSTART = 4'd8,
    PH_MIDDLE     = 4'd9,
    PH_TRAILING   = 4'd10,
    PH_DONE       = 4'd11
  } phase_t;

  typedef enum logic [2:0] {
    CL_TAGS   = 3'd0,
    CL_PREFIX = 3'd1,
    CL_CMD    = 3'd2,
    CL_MIDDLE = 3'd3,
    CL_TRAIL  = 3'd4,
    CL_SEP    = 3'd5,
    CL_TERM   = 3'd6,
    CL_IGN    = 3'd7
  } byte_class_t;

  typedef struct packed {
    phase_t                 phase;
    logic [1:0]             digits;
    logic [PENDING_W-1:0]   pending;
    logic                   line_error;
    logic                   numeric;
    logic                   cr_seen;
    logic                   drop;
  } line_state_t;

  typedef struct packed {
    byte_class_t  cls;
    logic [3:0]   pidx;
    logic         lend;
    logic         lvalid;
    logic [4:0]   pcount;
    logic         numc;
    logic         dropped;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/irct_step.sv =====
// Per-byte classification and next-state logic of the tokenizer.
`default_nettype none
module irct_step #(
  parameter int MAX_PARAMS = irct_pkg::DEF_MAX_PARAMS,
  parameter int PCW        = $clog2(MAX_PARAMS + 1)
) (
  input  irct_pkg::line_state_t  st,
  input  logic [PCW-1:0]         params,
  input  logic [7:0]             data_byte,
  input  logic [4:0]             param_limit,
  input  logic [10:0]            max_line_bytes,
  output irct_pkg::line_state_t  st_next,
  output logic [PCW-1:0]         params_next,
  output irct_pkg::result_t      res
);
  import irct_pkg::*;

  localparam int W = PCW + 5;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_AT    = 8'h40;

  logic                 is_digit, is_letter, is_sp, is_cr;
  logic                 text_ok, limit_hit;
  phase_t               p;
  byte_class_t          cls;
  logic [W-1:0]         params_w, pidx_w;
  logic [PENDING_W-1:0] pend_next;

  assign is_digit  = (data_byte >= 8'h30) && (data_byte <= 8'h39);
  assign is_letter = ((data_byte >= 8'h41) && (data_byte <= 8'h5A)) ||
                     ((data_byte >= 8'h61) && (data_byte <= 8'h7A));
  assign is_sp     = (data_byte == CH_SPACE);
  assign is_cr     = (data_byte == CH_CR);
  assign text_ok   = (st.phase == PH_CMDALPHA) || (st.phase == PH_AFTER) ||
                     (st.phase == PH_MIDDLE) || (st.phase == PH_TRAILING);
  assign limit_hit = (W'(params) >= W'(param_limit)) || (W'(params) >= W'(MAX_PARAMS));
  assign pend_next = st.pending + PENDING_W'(1);

  always_comb begin
    st_next     = st;
    params_next = params;
    res         = '0;
    res.cls     = CL_IGN;
    res.dropped = st.drop;
    cls         = CL_IGN;
    params_w    = W'(params);
    pidx_w      = '0;

    p = st.phase;
    if ((p == PH_START) && (data_byte != CH_AT)) p = PH_PFXOPT;
    if ((p == PH_PFXOPT) && (data_byte != CH_COLON)) p = PH_CMDSTART;
    if ((p == PH_CMDALPHA) && !is_letter) p = PH_AFTER;
    if ((p == PH_MIDDLE) && (is_sp || is_cr)) p = PH_AFTER;
    if ((p == PH_TRAILING) && is_cr) p = PH_AFTER;

    if (!st.drop) begin
      if (data_byte == CH_LF) begin
        res.cls    = CL_TERM;
        res.lend   = 1'b1;
        res.lvalid = !(st.line_error || ((st.phase != PH_DONE) && !text_ok));
        res.pcount = params_w[4:0];
        res.numc   = st.numeric;
        st_next.phase      = PH_START;
        st_next.digits     = '0;
        st_next.pending    = '0;
        st_next.line_error = 1'b0;
        st_next.numeric    = 1'b0;
        st_next.cr_seen    = 1'b0;
        params_next        = '0;
      end else begin
        if (data_byte == CH_NUL) begin
          if ((st.phase != PH_DONE) && !text_ok) st_next.line_error = 1'b1;
          st_next.phase = PH_DONE;
        end else begin
          unique case (p)
            PH_START: begin
              st_next.phase = PH_TAGS;
              cls = CL_TAGS;
            end
            PH_PFXOPT: begin
              st_next.phase = PH_PREFIX;
              cls = CL_PREFIX;
            end
            PH_TAGS: begin
              if (is_sp) begin
                st_next.phase = PH_PFXOPT;
                cls = CL_SEP;
              end else begin
                st_next.phase = PH_TAGS;
                cls = CL_TAGS;
              end
            end
            PH_PREFIX: begin
              if (is_sp) begin
                st_next.phase = PH_CMDSTART;
                cls = CL_SEP;
              end else begin
                st_next.phase = PH_PREFIX;
                cls = CL_PREFIX;
              end
            end
            PH_CMDSTART: begin
              if (is_digit) begin
                st_next.digits = 2'd1;
                st_next.phase  = PH_CMDNUM;
                cls = CL_CMD;
              end else if (is_letter) begin
                st_next.phase = PH_CMDALPHA;
                cls = CL_CMD;
              end else begin
                st_next.line_error = 1'b1;
                st_next.phase      = PH_DONE;
              end
            end
            PH_CMDNUM: begin
              if (!is_digit) begin
                st_next.line_error = 1'b1;
                st_next.phase      = PH_DONE;
              end else begin
                st_next.digits = st.digits + 2'd1;
                if (st.digits == 2'd2) begin
                  st_next.numeric = 1'b1;
                  st_next.phase   = PH_AFTER;
                end
                cls = CL_CMD;
              end
            end
            PH_CMDALPHA: begin
              cls = CL_CMD;
            end
            PH_AFTER: begin
              if (st.cr_seen || !(is_sp || is_cr) || (is_sp && limit_hit)) begin
                st_next.line_error = 1'b1;
                st_next.phase      = PH_DONE;
              end else if (is_sp) begin
                st_next.phase = PH_PARAMSTART;
                cls = CL_SEP;
              end else begin
                st_next.phase   = PH_AFTER;
                st_next.cr_seen = 1'b1;
                cls = CL_TERM;
              end
            end
            PH_PARAMSTART: begin
              if (is_sp || is_cr) begin
                st_next.line_error = 1'b1;
                st_next.phase      = PH_DONE;
              end else begin
                params_next = params + PCW'(1);
                if (data_byte == CH_COLON) begin
                  st_next.phase = PH_TRAILING;
                  cls = CL_TRAIL;
                end else begin
                  st_next.phase = PH_MIDDLE;
                  cls = CL_MIDDLE;
                end
              end
            end
            PH_MIDDLE: begin
              cls = CL_MIDDLE;
            end
            PH_TRAILING: begin
              cls = CL_TRAIL;
            end
            default: begin
              cls = CL_IGN;
            end
          endcase
          if (((cls == CL_MIDDLE) || (cls == CL_TRAIL)) && (params_next != '0)) begin
            pidx_w = W'(params_next) - W'(1);
          end
        end
        st_next.pending = pend_next;
        if (pend_next > PENDING_W'(max_line_bytes)) begin
          st_next.drop = 1'b1;
          cls    = CL_IGN;
          pidx_w = '0;
        end
        res.cls     = cls;
        res.pidx    = pidx_w[3:0];
        res.dropped = st_next.drop;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/irc_line_tokenizer.sv =====
// Top level of the IRC line tokenizer: input register, line state, result register.
`default_nettype none
// One byte enters per cycle and its label leaves in the cycle after it is taken
// from the input register: an input register, the per-byte phase logic and a
// result register make a two-stage pipeline that accepts a new byte in every
// cycle while the result side takes them. A stalled result holds the pipeline;
// bytes are classified in arrival order against the line state left by the
// byte before. Configuration writes take effect at once and are meant for an
// idle block. Once the pending line exceeds max_line_bytes, dropped stays set
// and every later byte is labelled ignored until reset.
module irc_line_tokenizer #(
  parameter int MAX_PARAMS = irct_pkg::DEF_MAX_PARAMS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  byte_class,
  output logic [3:0]  param_index,
  output logic        line_end,
  output logic        line_valid,
  output logic [4:0]  param_count,
  output logic        numeric_command,
  output logic        dropped
);
  import irct_pkg::*;

  localparam int PCW = $clog2(MAX_PARAMS + 1);

  logic [4:0]     param_limit;
  logic [10:0]    max_line_bytes;
  logic           s1_valid;
  logic [7:0]     s1_byte;
  line_state_t    st, st_next;
  logic [PCW-1:0] params, params_next;
  result_t        res, out_res;
  logic           advance;

  assign advance  = out_ready || !out_valid;
  assign in_ready = !s1_valid || advance;

  irct_step #(
    .MAX_PARAMS (MAX_PARAMS),
    .PCW        (PCW)
  ) u_step (
    .st             (st),
    .params         (params),
    .data_byte      (s1_byte),
    .param_limit    (param_limit),
    .max_line_bytes (max_line_bytes),
    .st_next        (st_next),
    .params_next    (params_next),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      param_limit    <= RESET_PARAM_LIMIT;
      max_line_bytes <= RESET_MAX_LINE;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PARAM_LIMIT:    param_limit    <= cfg_data[4:0];
        REG_MAX_LINE_BYTES: max_line_bytes <= cfg_data;
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= '{phase: PH_START, default: '0};
      params    <= '0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (advance) out_valid <= s1_valid;
      if (s1_valid && advance) begin
        st     <= st_next;
        params <= params_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_byte <= data_byte;
    if (s1_valid && advance) out_res <= res;
  end

  assign byte_class      = out_res.cls;
  assign param_index     = out_res.pidx;
  assign line_end        = out_res.lend;
  assign line_valid      = out_res.lvalid;
  assign param_count     = out_res.pcount;
  assign numeric_command = out_res.numc;
  assign dropped         = out_res.dropped;

endmodule
`default_nettype wire
